/* rtl/assert_macros.svh */
// Assertion macros shared by the timer event table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tet_pkg.sv */
// Package with shared types and codes of the timer event table.
`default_nettype none
package tet_pkg;
  localparam logic [1:0] FuncAdd    = 2'd0;
  localparam logic [1:0] FuncRemove = 2'd1;
  localparam logic [1:0] FuncTick   = 2'd2;
  localparam logic [1:0] FuncClear  = 2'd3;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;
  localparam logic [1:0] StatusNullTag  = 2'd3;

  localparam int unsigned StepReset = 100;

  // Control travelling along the row of slot cells.
  typedef struct packed {
    logic       add_hit;
    logic       rem_hit;
    logic       tick_sel;
    logic       clr;
  } cell_ctrl_t;
endpackage
`default_nettype wire

/* rtl/tet_cell.sv */
// One event slot: holds the used flag, remaining time, tag and argument.
`default_nettype none
module tet_cell #(
  parameter int unsigned TagBits = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tet_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic [30:0]           delay_i,
  input  wire logic [TagBits-1:0]    tag_i,
  input  wire logic [63:0]           arg_i,
  input  wire logic [15:0]           step_i,
  output logic                       used_o,
  output logic [TagBits-1:0]         tag_o,
  output logic [63:0]                arg_o,
  output logic                       expire_o
);
  logic        used_q, used_d;
  logic [31:0] rem_q, rem_d;
  logic [TagBits-1:0] tag_q, tag_d;
  logic [63:0] arg_q, arg_d;
  logic [32:0] diff;

  assign diff     = {1'b0, rem_q} - {17'd0, step_i};
  assign expire_o = used_q && (diff[32] || diff[31:0] == 32'd0);

  always_comb begin
    used_d = used_q;
    rem_d  = rem_q;
    tag_d  = tag_q;
    arg_d  = arg_q;
    if (ctrl_i.clr || ctrl_i.rem_hit || (ctrl_i.tick_sel && expire_o)) begin
      used_d = 1'b0;
    end else if (ctrl_i.add_hit) begin
      used_d = 1'b1;
      rem_d  = {1'b0, delay_i};
      tag_d  = tag_i;
      arg_d  = arg_i;
    end else if (ctrl_i.tick_sel && used_q) begin
      rem_d = diff[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    tag_q <= tag_d;
    arg_q <= arg_d;
  end

  assign used_o = used_q;
  assign tag_o  = tag_q;
  assign arg_o  = arg_q;
endmodule
`default_nettype wire

/* rtl/timer_event_table_core.sv */
// Top level of the timer event table: control sequencer over a row of slot cells.
//
// Channel  Direction  Content
// s_axis   in         tdata: func, cpu, delay_ms, handler_tag, event_arg
// m_axis   out        tdata: status, slot, expired_tag, expired_arg, running; tuser: kind; tlast
// cfg      in         tick_step_ms
//
// An add, remove or clear passes from its input transfer through a decide state, then a
// result state that registers the result, and back to idle. The first-free and tag-match
// search is combinational over the addressed CPU's slots. A tick walks the CPU's EVENTS
// slots one per cycle while the result register is free, then updates the running flag
// and registers the final result. Every cycle in which the result register is still
// held by the receiver stalls the walk or the final result. Reset clears all used flags
// and running flags at once; the step register resets to 100. The configuration
// channel is ready only in idle.
`default_nettype none
`include "assert_macros.svh"
module timer_event_table_core #(
  parameter int unsigned EVENTS   = 16,
  parameter int unsigned CPUS     = 4,
  parameter int unsigned TAG_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // func[1:0], cpu[3:2], delay_ms[34:4], handler_tag[50:35], event_arg[114:51]
  input  wire logic [119:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], slot[5:2], expired_tag[21:6], expired_arg[85:22], running[86]
  output logic [87:0]       m_axis_tdata,
  // kind[0]
  output logic              m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data
);
  localparam int unsigned NSlots = CPUS * EVENTS;
  localparam int unsigned SlotW  = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int unsigned CpuW   = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int unsigned IdxW   = (NSlots > 1) ? $clog2(NSlots) : 1;

  typedef enum logic [1:0] {StIdle, StOp, StTick, StDone} state_e;

  state_e             state_q;
  logic [15:0]        step_q;
  logic [1:0]         func_q;
  logic [1:0]         cpu_q;
  logic [30:0]        delay_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [63:0]        arg_q;
  logic [SlotW:0]     idx_q;
  logic [CPUS-1:0]    run_q;
  logic [1:0]         status_q;
  logic [SlotW-1:0]   slot_q;
  logic               ovalid_q;
  logic [87:0]        odata_q;
  logic               ouser_q;
  logic               olast_q;

  tet_pkg::cell_ctrl_t ctrl [NSlots];
  logic [NSlots-1:0]   used, expire;
  logic [TAG_BITS-1:0] ctag [NSlots];
  logic [63:0]         carg [NSlots];

  logic               valid_cpu;
  logic [CpuW-1:0]    cpu_idx;
  logic               free_found, match_found;
  logic [SlotW-1:0]   free_k, match_k;
  logic [NSlots-1:0]  sel_add, sel_rem;
  logic               out_free;
  logic [SlotW-1:0]   walk_k;
  logic               any_left;
  logic               any_keep;

  assign valid_cpu = {30'd0, cpu_q} < 32'(CPUS);
  assign cpu_idx   = CpuW'(cpu_q);
  assign walk_k    = idx_q[SlotW-1:0];
  assign out_free  = !ovalid_q || m_axis_tready;

  always_comb begin
    free_found  = 1'b0;
    match_found = 1'b0;
    free_k      = '0;
    match_k     = '0;
    any_left    = 1'b0;
    any_keep    = 1'b0;
    for (int k = EVENTS - 1; k >= 0; k--) begin
      if (!used[int'(cpu_idx) * EVENTS + k]) begin
        free_found = 1'b1;
        free_k     = SlotW'(k);
      end
      if (used[int'(cpu_idx) * EVENTS + k] && ctag[int'(cpu_idx) * EVENTS + k] == tag_q) begin
        match_found = 1'b1;
        match_k     = SlotW'(k);
      end
      if (used[int'(cpu_idx) * EVENTS + k]) begin
        any_left = 1'b1;
      end
      if (used[int'(cpu_idx) * EVENTS + k] &&
          (k < int'(idx_q) || !expire[int'(cpu_idx) * EVENTS + k])) begin
        any_keep = 1'b1;
      end
    end
  end

  logic op_go, tick_go;
  assign op_go   = state_q == StOp && valid_cpu && tag_q != '0;
  assign tick_go = state_q == StTick && valid_cpu && idx_q < (SlotW+1)'(EVENTS) && out_free;

  for (genvar s = 0; s < NSlots; s++) begin : g_cell
    localparam int unsigned C = s / EVENTS;
    localparam int unsigned K = s % EVENTS;
    assign ctrl[s].add_hit  = op_go && func_q == tet_pkg::FuncAdd && free_found &&
                              int'(cpu_idx) == C && free_k == SlotW'(K);
    assign ctrl[s].rem_hit  = op_go && func_q == tet_pkg::FuncRemove && match_found &&
                              int'(cpu_idx) == C && match_k == SlotW'(K);
    assign ctrl[s].tick_sel = tick_go && int'(cpu_idx) == C && walk_k == SlotW'(K);
    assign ctrl[s].clr      = state_q == StOp && func_q == tet_pkg::FuncClear;
    assign sel_add[s]       = ctrl[s].add_hit;
    assign sel_rem[s]       = ctrl[s].rem_hit;
    tet_cell #(.TagBits(TAG_BITS)) u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl[s]), .delay_i(delay_q), .tag_i(tag_q),
      .arg_i(arg_q), .step_i(step_q), .used_o(used[s]), .tag_o(ctag[s]),
      .arg_o(carg[s]), .expire_o(expire[s])
    );
  end

  logic [IdxW-1:0] wsel;
  assign wsel = IdxW'(int'(cpu_idx) * int'(EVENTS) + int'(walk_k));

  logic [15:0] tag16;
  always_comb begin
    tag16 = '0;
    for (int b = 0; b < 16; b++) begin
      if (b < TAG_BITS) tag16[b] = ctag[wsel][b];
    end
  end

  logic [15:0] in_tag16;
  logic [TAG_BITS-1:0] in_tag;
  assign in_tag16 = s_axis_tdata[50:35];
  always_comb begin
    in_tag = '0;
    for (int b = 0; b < TAG_BITS; b++) begin
      if (b < 16) in_tag[b] = in_tag16[b];
    end
  end

  assign s_axis_tready = state_q == StIdle;
  assign cfg_ready     = state_q == StIdle;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      step_q   <= 16'(tet_pkg::StepReset);
      run_q    <= '0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
      ouser_q  <= 1'b0;
      olast_q  <= 1'b0;
      idx_q    <= '0;
      status_q <= tet_pkg::StatusOk;
      slot_q   <= '0;
      func_q   <= tet_pkg::FuncAdd;
      cpu_q    <= '0;
      delay_q  <= '0;
      tag_q    <= '0;
      arg_q    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) step_q <= cfg_data;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            func_q  <= s_axis_tdata[1:0];
            cpu_q   <= s_axis_tdata[3:2];
            delay_q <= s_axis_tdata[34:4];
            tag_q   <= in_tag;
            arg_q   <= s_axis_tdata[114:51];
            idx_q   <= '0;
            status_q <= tet_pkg::StatusOk;
            slot_q  <= '0;
            state_q <= (s_axis_tdata[1:0] == tet_pkg::FuncTick) ? StTick : StOp;
          end
        end
        StOp: begin
          if (valid_cpu && func_q != tet_pkg::FuncClear) begin
            if (tag_q == '0) begin
              status_q <= tet_pkg::StatusNullTag;
            end else if (func_q == tet_pkg::FuncAdd) begin
              run_q[cpu_idx] <= 1'b1;
              if (free_found) slot_q <= free_k;
              else status_q <= tet_pkg::StatusFull;
            end else if (match_found) begin
              slot_q <= match_k;
            end else begin
              status_q <= tet_pkg::StatusNotFound;
            end
          end
          state_q <= StDone;
        end
        StTick: begin
          if (!valid_cpu) begin
            state_q <= StDone;
          end else if (idx_q == (SlotW+1)'(EVENTS)) begin
            if (!any_left) run_q[cpu_idx] <= 1'b0;
            state_q <= StDone;
          end else if (out_free) begin
            idx_q <= idx_q + 1'b1;
            if (expire[wsel]) begin
              ovalid_q <= 1'b1;
              ouser_q  <= 1'b1;
              olast_q  <= 1'b0;
              odata_q  <= {1'b0, run_q[cpu_idx] && any_keep, carg[wsel], tag16,
                           4'(walk_k), tet_pkg::StatusOk};
            end
          end
        end
        StDone: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            ouser_q  <= 1'b0;
            olast_q  <= 1'b1;
            odata_q  <= {1'b0, valid_cpu && run_q[cpu_idx], 64'd0, 16'd0, 4'(slot_q),
                         status_q};
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_IMPL(a_in_only_idle, clk_i, rst_ni,
    (s_axis_tvalid && s_axis_tready) |-> state_q == StIdle)
  `ASSERT_IMPL(a_one_hit, clk_i, rst_ni, $onehot0(sel_add | sel_rem))
  `ASSERT_NEXT(a_done_last, clk_i, rst_ni, state_q == StDone && out_free,
    m_axis_tvalid && m_axis_tlast)
endmodule
`default_nettype wire
